/* src/snow_pkg.sv */
package snow_pkg;

  // fixed field widths
  localparam int NOW_W       = 42;
  localparam int ID_W        = 63;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 16;

  // epoch offset in milliseconds
  localparam logic [NOW_W-1:0] TIME_OFFSET = 42'd910753871111;

  // parameter defaults
  localparam int WORKER_BITS_DEF    = 10;
  localparam int SEQ_BITS_DEF       = 12;
  localparam int STORE_SEQ_BITS_DEF = 13;
  localparam int BEGIN_BITS_DEF     = 10;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_WORKER = 2'd0,
    CFG_ROTATE = 2'd1
  } cfg_index_t;

  // reset value of the rotate enable register
  localparam logic ROTATE_RESET = 1'b1;

endpackage

/* src/snow_req_if.sv */
interface snow_req_if;
  logic                        valid;
  logic                        ready;
  logic [snow_pkg::NOW_W-1:0]  now_ms;

  modport source  (output valid, output now_ms, input ready);
  modport sink    (input valid, input now_ms, output ready);
  modport monitor (input valid, input now_ms, input ready);
endinterface

/* src/snow_res_if.sv */
interface snow_res_if;
  logic                       valid;
  logic                       ready;
  logic [snow_pkg::ID_W-1:0]  unique_id;
  logic                       status;

  modport source  (output valid, output unique_id, output status, input ready);
  modport sink    (input valid, input unique_id, input status, output ready);
  modport monitor (input valid, input unique_id, input status, input ready);
endinterface

/* src/snow_cfg_if.sv */
interface snow_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [snow_pkg::CFG_INDEX_W-1:0]  index;
  logic [snow_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/snow_time.sv */
module snow_time #(
  parameter int WORKER_BITS = snow_pkg::WORKER_BITS_DEF,
  parameter int SEQ_BITS    = snow_pkg::SEQ_BITS_DEF,
  localparam int TW = snow_pkg::ID_W - WORKER_BITS - SEQ_BITS
) (
  input  logic                        clk,
  input  logic                        rst,
  // request side
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [snow_pkg::NOW_W-1:0]  req_now,
  // toward the sequencer
  output logic                        t_valid,
  input  logic                        t_ready,
  output logic [TW-1:0]               t_value
);

  localparam int XW = (TW > snow_pkg::NOW_W) ? TW : snow_pkg::NOW_W;

  logic                        now_valid;
  logic [snow_pkg::NOW_W-1:0]  now_r;
  logic [snow_pkg::NOW_W-1:0]  last_time_ms;
  logic [snow_pkg::NOW_W-1:0]  now_clamped;
  logic [snow_pkg::NOW_W-1:0]  t_full;
  logic [XW-1:0]               t_ext;
  logic                        t_over;
  logic [TW-1:0]               t_sat;
  logic                        t_load;

  // last_time_ms starts at the offset and never drops, so the subtract cannot wrap
  assign now_clamped = (now_r < last_time_ms) ? last_time_ms : now_r;
  assign t_full      = now_clamped - snow_pkg::TIME_OFFSET;
  assign t_ext       = XW'(t_full);
  assign t_over      = (t_ext >> TW) != '0;
  assign t_sat       = t_over ? '1 : TW'(t_ext);

  assign t_load    = now_valid && (!t_valid || t_ready);
  assign req_ready = !now_valid || !t_valid || t_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      now_valid    <= 1'b0;
      t_valid      <= 1'b0;
      last_time_ms <= snow_pkg::TIME_OFFSET;
    end else begin
      now_valid <= (req_valid && req_ready) || (now_valid && !t_load);
      t_valid   <= t_load || (t_valid && !t_ready);
      if (t_load) begin
        last_time_ms <= now_clamped;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      now_r <= req_now;
    end
    if (t_load) begin
      t_value <= t_sat;
    end
  end

endmodule

/* src/snow_seq.sv */
module snow_seq #(
  parameter int WORKER_BITS    = snow_pkg::WORKER_BITS_DEF,
  parameter int SEQ_BITS       = snow_pkg::SEQ_BITS_DEF,
  parameter int STORE_SEQ_BITS = snow_pkg::STORE_SEQ_BITS_DEF,
  parameter int BEGIN_BITS     = snow_pkg::BEGIN_BITS_DEF,
  localparam int TW = snow_pkg::ID_W - WORKER_BITS - SEQ_BITS
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [WORKER_BITS-1:0]     worker_number,
  input  logic                       begin_rotate_enable,
  // from the time stage
  input  logic                       t_valid,
  output logic                       t_ready,
  input  logic [TW-1:0]              t_value,
  // result side
  output logic                       res_valid,
  input  logic                       res_ready,
  output logic [snow_pkg::ID_W-1:0]  res_id,
  output logic                       res_status
);

  // compare width: holds begin + max sequence without overflow
  localparam int MW0 = (STORE_SEQ_BITS > BEGIN_BITS) ? STORE_SEQ_BITS : BEGIN_BITS;
  localparam int MW1 = (MW0 > SEQ_BITS) ? MW0 : SEQ_BITS;
  localparam int CW  = MW1 + 1;
  localparam logic [CW-1:0] SEQ_MAX = CW'((64'd1 << SEQ_BITS) - 64'd1);

  logic [TW-1:0]             stored_time;
  logic [BEGIN_BITS-1:0]     begin_value;
  logic [STORE_SEQ_BITS-1:0] seq_counter;

  logic [TW-1:0]             stored_time_next;
  logic [BEGIN_BITS-1:0]     begin_value_next;
  logic [STORE_SEQ_BITS-1:0] seq_base;
  logic [STORE_SEQ_BITS-1:0] seq_inc;
  logic [STORE_SEQ_BITS-1:0] seq_counter_next;
  logic [CW-1:0]             seq_limit;
  logic                      exhausted;
  logic [SEQ_BITS-1:0]       seq_field;
  logic                      take;

  always_comb begin
    if (t_value > stored_time) begin
      // new millisecond: restart at the begin value
      begin_value_next = begin_rotate_enable ? BEGIN_BITS'(CW'(seq_counter)) : '0;
      stored_time_next = t_value;
      seq_base         = STORE_SEQ_BITS'(CW'(begin_value_next));
    end else begin
      begin_value_next = begin_value;
      stored_time_next = stored_time;
      seq_base         = seq_counter;
    end
    seq_limit        = CW'(begin_value_next) + SEQ_MAX;
    exhausted        = CW'(seq_base) >= seq_limit;
    seq_inc          = seq_base + STORE_SEQ_BITS'(1);
    seq_counter_next = exhausted ? seq_base : seq_inc;
    seq_field        = SEQ_BITS'(CW'(seq_inc));
  end

  assign t_ready = !res_valid || res_ready;
  assign take    = t_valid && t_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid   <= 1'b0;
      stored_time <= '0;
      begin_value <= '0;
      seq_counter <= '0;
    end else begin
      res_valid <= take || (res_valid && !res_ready);
      if (take) begin
        stored_time <= stored_time_next;
        begin_value <= begin_value_next;
        seq_counter <= seq_counter_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_status <= exhausted;
      res_id     <= exhausted ? '0 : {stored_time_next, worker_number, seq_field};
    end
  end

endmodule

/* src/snowflake_id_generator_unit.sv */
// Snowflake id generator: every request carries the current time in ms and gets
// back one 63-bit id, {time since epoch offset, worker number, sequence}, or
// status 1 with id 0 when the 2^SEQ_BITS - 1 ids of the current millisecond are
// used up. Time is clamped so it never runs backwards and saturates at the time
// field's maximum. Throughput is one request per cycle with no bubbles while
// the result side takes results; an accepted request passes the input register,
// then the time register, then the result register. The rate is set by the
// sequence update in the sequencer stage, which forms its next state
// combinationally from its own registers. While a result waits, up to two more
// requests are taken into the input and time registers before the request side
// stalls. Configuration (worker number, sequence rotate enable) is always ready
// and must only be written while no request is in flight; writes to unknown
// register indexes are dropped.
module snowflake_id_generator_unit #(
  parameter int WORKER_BITS    = snow_pkg::WORKER_BITS_DEF,
  parameter int SEQ_BITS       = snow_pkg::SEQ_BITS_DEF,
  parameter int STORE_SEQ_BITS = snow_pkg::STORE_SEQ_BITS_DEF,
  parameter int BEGIN_BITS     = snow_pkg::BEGIN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  snow_req_if.sink      request,
  snow_res_if.source    result,
  snow_cfg_if.sink      cfg
);

  localparam int TW = snow_pkg::ID_W - WORKER_BITS - SEQ_BITS;

  // configuration registers
  logic [WORKER_BITS-1:0] worker_number;
  logic                   begin_rotate_enable;

  // time stage to sequencer
  logic                   t_valid;
  logic                   t_ready;
  logic [TW-1:0]          t_value;

  // config writes are registered when valid, no back-pressure
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      worker_number       <= '0;
      begin_rotate_enable <= snow_pkg::ROTATE_RESET;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        snow_pkg::CFG_WORKER: worker_number       <= WORKER_BITS'(cfg.data);
        snow_pkg::CFG_ROTATE: begin_rotate_enable <= cfg.data[0];
        default: ; // unknown index, write dropped
      endcase
    end
  end

  // clamp against the last seen time, remove the epoch offset, saturate
  snow_time #(
    .WORKER_BITS (WORKER_BITS),
    .SEQ_BITS    (SEQ_BITS)
  ) u_time (
    .clk       (clk),
    .rst       (rst),
    .req_valid (request.valid),
    .req_ready (request.ready),
    .req_now   (request.now_ms),
    .t_valid   (t_valid),
    .t_ready   (t_ready),
    .t_value   (t_value)
  );

  // per-millisecond sequence, exhaustion check and id packing
  snow_seq #(
    .WORKER_BITS    (WORKER_BITS),
    .SEQ_BITS       (SEQ_BITS),
    .STORE_SEQ_BITS (STORE_SEQ_BITS),
    .BEGIN_BITS     (BEGIN_BITS)
  ) u_seq (
    .clk                 (clk),
    .rst                 (rst),
    .worker_number       (worker_number),
    .begin_rotate_enable (begin_rotate_enable),
    .t_valid             (t_valid),
    .t_ready             (t_ready),
    .t_value             (t_value),
    .res_valid           (result.valid),
    .res_ready           (result.ready),
    .res_id              (result.unique_id),
    .res_status          (result.status)
  );

endmodule

/* src/snow_checker.sv */
module snow_checker #(
  parameter int WORKER_BITS = snow_pkg::WORKER_BITS_DEF,
  parameter int SEQ_BITS    = snow_pkg::SEQ_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  input  logic                       req_ready,
  input  logic                       res_valid,
  input  logic                       res_ready,
  input  logic [snow_pkg::ID_W-1:0]  res_id,
  input  logic                       res_status
);

  localparam int TW    = snow_pkg::ID_W - WORKER_BITS - SEQ_BITS;
  localparam int DEPTH = 3;

  logic [1:0]    in_flight;
  logic [TW-1:0] last_ts;
  logic          have_ts;
  logic [TW-1:0] cur_ts;
  logic          req_take;
  logic          res_take;

  assign req_take = req_valid && req_ready;
  assign res_take = res_valid && res_ready;
  assign cur_ts   = res_id[snow_pkg::ID_W-1 -: TW];

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= '0;
      have_ts   <= 1'b0;
    end else begin
      in_flight <= in_flight + 2'(req_take) - 2'(res_take);
      if (res_take && !res_status) begin
        have_ts <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && !res_status) begin
      last_ts <= cur_ts;
    end
  end

  // a result only exists for a request that went in
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> in_flight != 2'd0)
    else $error("result without pending request");

  // never more requests inside than pipeline registers
  a_capacity: assert property (@(posedge clk) disable iff (rst)
    (in_flight == 2'(DEPTH)) |-> !req_take || res_take)
    else $error("request accepted with pipeline full");

  // exhaustion reports a zero id
  a_exhaust_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_status) |-> res_id == '0)
    else $error("nonzero id with exhausted status");

  // time field of delivered ids never goes backwards
  a_time_mono: assert property (@(posedge clk) disable iff (rst)
    (res_take && !res_status && have_ts) |-> cur_ts >= last_ts)
    else $error("id time field went backwards");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=>
      res_valid && $stable(res_id) && $stable(res_status))
    else $error("stalled result changed");

endmodule

bind snowflake_id_generator_unit snow_checker #(
  .WORKER_BITS (WORKER_BITS),
  .SEQ_BITS    (SEQ_BITS)
) u_snow_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (request.valid),
  .req_ready  (request.ready),
  .res_valid  (result.valid),
  .res_ready  (result.ready),
  .res_id     (result.unique_id),
  .res_status (result.status)
);

/* sim/snowflake_id_generator_unit_tb.sv */
`timescale 1ns / 1ps

module snowflake_id_generator_unit_tb;

  localparam int NOW_W       = snow_pkg::NOW_W;
  localparam int ID_W        = snow_pkg::ID_W;
  localparam int CFG_INDEX_W = snow_pkg::CFG_INDEX_W;
  localparam int CFG_DATA_W  = snow_pkg::CFG_DATA_W;
  localparam logic [NOW_W-1:0] TIME_OFFSET = snow_pkg::TIME_OFFSET;

  // id field layout
  localparam int WORKER_W = snow_pkg::WORKER_BITS_DEF;
  localparam int SEQ_W    = snow_pkg::SEQ_BITS_DEF;
  localparam int CNT_W    = snow_pkg::STORE_SEQ_BITS_DEF;
  localparam int START_W  = snow_pkg::BEGIN_BITS_DEF;
  localparam int TIME_W   = ID_W - WORKER_W - SEQ_W;
  // ids per millisecond before the sequence runs dry
  localparam int SEQ_SPAN = (1 << SEQ_W) - 1;

  // latest time that still fits the id time field, and the top of the port
  localparam logic [NOW_W-1:0] NOW_HIGH = 42'd3109777126662;
  localparam logic [NOW_W-1:0] NOW_MAX  = '1;

  // register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  localparam int MAX_REPORTS   = 10;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_LIMIT   = 20000;

  typedef struct packed {
    logic [ID_W-1:0] unique_id;
    logic            status;
  } id_result_t;

  // predicts every id from the accepted requests and checks the returned ones
  class id_ledger;
    id_result_t            ids_due[$];
    logic [NOW_W-1:0]      last_ms;
    logic [TIME_W-1:0]     epoch_ms;
    logic [START_W-1:0]    seq_start;
    logic [CNT_W-1:0]      seq_cnt;
    logic [WORKER_W-1:0]   worker;
    logic                  rotate;
    int                    mismatches;
    int                    requests;
    int                    checked;
    int                    exhausted;
    int                    writes;

    function new();
      last_ms    = TIME_OFFSET;
      epoch_ms   = '0;
      seq_start  = '0;
      seq_cnt    = '0;
      worker     = '0;
      rotate     = snow_pkg::ROTATE_RESET;
      mismatches = 0;
      requests   = 0;
      checked    = 0;
      exhausted  = 0;
      writes     = 0;
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      writes++;
      unique case (idx)
        snow_pkg::CFG_WORKER: worker = data[WORKER_W-1:0];
        snow_pkg::CFG_ROTATE: rotate = data[0];
        default: ;
      endcase
    endfunction

    function void note_request(logic [NOW_W-1:0] now);
      logic [NOW_W-1:0] clamped;
      logic [NOW_W-1:0] since;
      logic [TIME_W-1:0] t;
      id_result_t r;
      requests++;
      // time never runs backwards
      clamped = (now < last_ms) ? last_ms : now;
      last_ms = clamped;
      since   = (clamped >= TIME_OFFSET) ? clamped - TIME_OFFSET : '0;
      // saturate at the top of the time field
      t = (since > NOW_W'({TIME_W{1'b1}})) ? '1 : since[TIME_W-1:0];
      // new millisecond: restart the sequence, rotated or from zero
      if (t > epoch_ms) begin
        seq_start = rotate ? seq_cnt[START_W-1:0] : '0;
        epoch_ms  = t;
        seq_cnt   = CNT_W'(seq_start);
      end
      if (int'(seq_cnt) >= int'(seq_start) + SEQ_SPAN) begin
        r.unique_id = '0;
        r.status    = 1'b1;
        exhausted++;
      end else begin
        seq_cnt     = seq_cnt + CNT_W'(1);
        r.unique_id = {epoch_ms, worker, seq_cnt[SEQ_W-1:0]};
        r.status    = 1'b0;
      end
      ids_due.push_back(r);
    endfunction

    function void check_result(logic [ID_W-1:0] got_id, logic got_status);
      id_result_t want;
      if (ids_due.size() == 0) begin
        flag($sformatf("id %h status %0d with no request pending", got_id, got_status));
        return;
      end
      want = ids_due.pop_front();
      checked++;
      if (got_id !== want.unique_id)
        flag($sformatf("result %0d unique_id: expected %h, got %h",
                       checked, want.unique_id, got_id));
      if (got_status !== want.status)
        flag($sformatf("result %0d status: expected %0d, got %0d",
                       checked, want.status, got_status));
    endfunction

    function int pending();
      return ids_due.size();
    endfunction

    // anything still owed at the end is a failure
    function void settle();
      if (ids_due.size() != 0)
        flag($sformatf("%0d ids never returned", ids_due.size()));
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  snow_req_if req_if ();
  snow_res_if res_if ();
  snow_cfg_if cfg_if ();

  snowflake_id_generator_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if),
    .cfg     (cfg_if)
  );

  id_ledger         ledger = new();
  int               send_idle_pct = 16;
  int               recv_idle_pct = 62;
  logic             hold_ask = 1'b0;
  int               hold_left = 0;
  // the wall clock the well-formed requests follow
  logic [NOW_W-1:0] wall_ms;

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #20_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // all handshakes are sampled at the rising edge, before the block updates
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_if.valid && cfg_if.ready) ledger.write_reg(cfg_if.index, cfg_if.data);
      if (req_if.valid && req_if.ready) ledger.note_request(req_if.now_ms);
      if (res_if.valid && res_if.ready) ledger.check_result(res_if.unique_id, res_if.status);
    end
  end

  // result side: random back-pressure, or a long hold-off when asked for
  always @(negedge clk) begin
    if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      res_if.ready = 1'b0;
      hold_left--;
    end else begin
      res_if.ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // offer one request, with random idle cycles in front; returns at a falling edge
  // with valid still high so back-to-back requests need no toggle
  task automatic push_request(input logic [NOW_W-1:0] now);
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk);
    end
    req_if.valid  = 1'b1;
    req_if.now_ms = now;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    @(negedge clk);
  endtask

  // register write; only called with nothing in flight
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_if.valid = 1'b1;
    cfg_if.index = idx;
    cfg_if.data  = data;
    do @(posedge clk); while (cfg_if.ready !== 1'b1);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // stop offering and wait until every predicted id is back
  task automatic drain_ids();
    int waited;
    waited = 0;
    req_if.valid = 1'b0;
    while (ledger.pending() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // change idle rates away from the falling edge the result side acts on
  task automatic set_idling(input int send_pct, input int recv_pct);
    req_if.valid = 1'b0;
    @(posedge clk);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    @(negedge clk);
  endtask

  // result side stops for a long stretch; the block fills and stalls requests
  task automatic ask_hold();
    req_if.valid = 1'b0;
    @(posedge clk);
    hold_ask = 1'b1;
    @(negedge clk);
  endtask

  // mostly a plausible clock: repeats, small steps, jumps; some late or garbage times
  task automatic random_stretch(input int count);
    int               sel;
    logic [63:0]      noise;
    logic [NOW_W-1:0] now;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 45) begin
        now = wall_ms;
      end else if (sel < 70) begin
        wall_ms = wall_ms + NOW_W'(1);
        now     = wall_ms;
      end else if (sel < 80) begin
        wall_ms = wall_ms + NOW_W'($urandom_range(5000, 2));
        now     = wall_ms;
      end else if (sel < 88) begin
        now = wall_ms - NOW_W'($urandom_range(1000, 1));
      end else begin
        noise = {$urandom(), $urandom()};
        now   = NOW_W'(noise % {22'd0, wall_ms});
      end
      push_request(now);
    end
  endtask

  // corner requests right after reset
  task automatic directed_corners();
    // time zero, below the epoch, then the epoch itself
    push_request('0);
    push_request(TIME_OFFSET);
    // millisecond advance with rotation on, a repeat, then backwards steps
    push_request(TIME_OFFSET + NOW_W'(1));
    push_request(TIME_OFFSET + NOW_W'(1));
    push_request(TIME_OFFSET);
    push_request(42'd5);
    push_request(TIME_OFFSET + NOW_W'(2));
    drain_ids();
    // full-width data is masked; spare indexes must change nothing
    write_reg(snow_pkg::CFG_WORKER, 16'hFFFF);
    write_reg(snow_pkg::CFG_ROTATE, 16'hFFFE);
    write_reg(CFG_SPARE_A, 16'h0155);
    write_reg(CFG_SPARE_B, 16'hFFFF);
    push_request(TIME_OFFSET + NOW_W'(2));
    push_request(TIME_OFFSET + NOW_W'(3));
    push_request(TIME_OFFSET + NOW_W'(3));
    push_request(TIME_OFFSET + NOW_W'(9));
    push_request(TIME_OFFSET + NOW_W'(4));
    drain_ids();
    write_reg(snow_pkg::CFG_WORKER, 16'h02AA);
    write_reg(snow_pkg::CFG_ROTATE, 16'h0001);
    push_request(TIME_OFFSET + NOW_W'(10));
    push_request(TIME_OFFSET + NOW_W'(10));
    push_request(TIME_OFFSET + NOW_W'(11));
    wall_ms = TIME_OFFSET + NOW_W'(11);
  endtask

  // last millisecond of the time field, past it, and the top of the port
  task automatic time_saturation();
    push_request(NOW_HIGH - NOW_W'(3));
    push_request(NOW_HIGH - NOW_W'(3));
    push_request(NOW_HIGH);
    push_request(NOW_HIGH + NOW_W'(1));
    push_request(NOW_MAX);
    push_request(NOW_MAX);
    push_request('0);
  endtask

  initial begin
    req_if.valid  = 1'b0;
    req_if.now_ms = '0;
    res_if.ready  = 1'b0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = snow_pkg::CFG_WORKER;
    cfg_if.data   = '0;
    wall_ms       = TIME_OFFSET;
    repeat (5) @(negedge clk);
    rst = 1'b0;

    // phase 1: light request gaps, heavy result back-pressure
    directed_corners();
    drain_ids();
    write_reg(snow_pkg::CFG_WORKER, 16'($urandom()));
    write_reg(snow_pkg::CFG_ROTATE, 16'h0001);
    random_stretch(250);
    ask_hold();
    random_stretch(270);
    drain_ids();

    // phase 2: worker zero, no rotation, roles of the idle rates swapped
    write_reg(snow_pkg::CFG_WORKER, 16'h0000);
    write_reg(snow_pkg::CFG_ROTATE, 16'h0000);
    set_idling(62, 16);
    random_stretch(250);
    // sender pause until everything is back
    drain_ids();
    random_stretch(270);
    drain_ids();

    // phase 3: top worker, rotation back on, full rate both sides
    write_reg(snow_pkg::CFG_WORKER, 16'h03FF);
    write_reg(snow_pkg::CFG_ROTATE, 16'h0001);
    set_idling(0, 0);
    random_stretch(480);
    time_saturation();
    drain_ids();

    ledger.settle();
    $display("run: %0d requests, %0d ids checked, %0d exhausted, %0d register writes",
             ledger.requests, ledger.checked, ledger.exhausted, ledger.writes);
    $display("run: backward and saturated time, rotation on and off, stalls and hold-off");
    if (ledger.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("mismatch total: %0d", ledger.mismatches);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
